// ===== hdl/mdm_pkg.sv =====
// Package: microcode types, control store and register map of the mecanum drive mixer.
package mdm_pkg;

    // Register map, by word index of the configuration port
    typedef enum logic [2:0] {
        REG_DEADBAND   = 3'd0,
        REG_RESCALE    = 3'd1,
        REG_GYRO_EN    = 3'd2,
        REG_OL_GAIN    = 3'd3,
        REG_KP         = 3'd4,
        REG_KI         = 3'd5
    } t_reg;

    // Multiplier operand selection
    typedef enum logic [2:0] {
        MS_NONE = 3'd0,
        MS_X    = 3'd1,
        MS_Y    = 3'd2,
        MS_T    = 3'd3,
        MS_KP   = 3'd4,
        MS_KI   = 3'd5,
        MS_OL   = 3'd6
    } t_msrc;

    // Writeback operation; most consume the registered product
    typedef enum logic [2:0] {
        WB_NONE = 3'd0,
        WB_X    = 3'd1,
        WB_Y    = 3'd2,
        WB_T    = 3'd3,
        WB_ERR  = 3'd4,
        WB_TSET = 3'd5,
        WB_TADD = 3'd6,
        WB_OUT  = 3'd7
    } t_wb;

    typedef enum logic [1:0] {
        J_NONE   = 2'd0,
        J_OPEN   = 2'd1,
        J_ALWAYS = 2'd2
    } t_jmp;

    localparam int STEP_W = 4;

    typedef struct packed {
        t_msrc             msrc;
        t_wb               wb;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    localparam logic [STEP_W-1:0] STEP_OPEN = 4'd8;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd10;

    // Control store: one word per step
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] s);
        t_ctrl c;
        case (s)
            4'd0:    c = '{MS_X,    WB_NONE, J_NONE,   4'd0};
            4'd1:    c = '{MS_Y,    WB_X,    J_NONE,   4'd0};
            4'd2:    c = '{MS_T,    WB_Y,    J_NONE,   4'd0};
            4'd3:    c = '{MS_NONE, WB_T,    J_OPEN,   STEP_OPEN};
            4'd4:    c = '{MS_NONE, WB_ERR,  J_NONE,   4'd0};
            4'd5:    c = '{MS_KP,   WB_NONE, J_NONE,   4'd0};
            4'd6:    c = '{MS_KI,   WB_TSET, J_NONE,   4'd0};
            4'd7:    c = '{MS_NONE, WB_TADD, J_ALWAYS, STEP_OUT};
            4'd8:    c = '{MS_OL,   WB_NONE, J_NONE,   4'd0};
            4'd9:    c = '{MS_NONE, WB_TSET, J_NONE,   4'd0};
            4'd10:   c = '{MS_NONE, WB_OUT,  J_NONE,   4'd0};
            default: c = '{MS_NONE, WB_OUT,  J_NONE,   4'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/mecanum_drive_mixer_with_yaw_pi_unit.sv =====
// Top level: microcoded mecanum drive mixer with deadband and PI yaw-rate loop.
//
//   channel   direction  handshake                 payload
//   -------   ---------  ------------------------  ----------------------------------
//   input     in         i_in_valid / o_in_stall   stick x/y/twist, enable, yaw rate
//   result    out        o_out_valid / i_out_stall four wheel drive commands
//   config    in         psel/penable/pwrite       six registers at paddr 4*i
//
// A request steps through the control store from acceptance to the result
// register, with the gyro loop steps only while the loop is on; the steps are set
// by the one shared multiplier, which the control store visits once per product
// (three deadbands, then Kp and Ki or the open-loop gain). A new request is
// accepted the cycle after the program ends, even while the previous result still
// waits. The last step holds while the result register is full and stalled.
// Reset clears the integrator, the control and loads the register defaults;
// there is no clearing pass.
module mecanum_drive_mixer_with_yaw_pi_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [15:0]  i_stick_x,
    input  logic signed [15:0]  i_stick_y,
    input  logic signed [15:0]  i_stick_twist,
    input  logic                i_twist_enable,
    input  logic signed [15:0]  i_measured_yaw_rate,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [15:0]  o_front_left_drive,
    output logic signed [15:0]  o_front_right_drive,
    output logic signed [15:0]  o_rear_left_drive,
    output logic signed [15:0]  o_rear_right_drive,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import mdm_pkg::*;

    // configuration registers
    logic [14:0] r_deadband;
    logic [15:0] r_rescale;
    logic        r_gyro_en;
    logic [15:0] r_ol_gain;
    logic [15:0] r_kp;
    logic [15:0] r_ki;

    // request registers
    logic signed [15:0] r_x, r_y, r_t, r_meas;
    logic               r_ten;

    // sequencer
    logic              r_run;
    logic [STEP_W-1:0] r_step;
    t_ctrl             ctrl;

    // datapath
    logic signed [49:0] r_prod;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod_bias;
    logic signed [37:0] prod_rnd;
    logic signed [15:0] r_strafe, r_dy;
    logic signed [16:0] r_z;
    logic signed [17:0] r_err;
    logic signed [31:0] r_sum;
    logic signed [37:0] r_turn;

    // results
    logic               r_out_valid;
    logic signed [15:0] r_fl, r_fr, r_rl, r_rr;

    logic in_acc, cfg_wr, out_free, jump;

    // Magnitude past the deadband, zero inside the band
    function automatic logic signed [32:0] db_excess(input logic signed [15:0] v,
                                                     input logic [14:0] db);
        logic signed [16:0] ve;
        logic [16:0]        mag;
        ve  = {v[15], v};
        mag = v[15] ? 17'(-ve) : 17'(ve);
        if (mag > {2'b00, db}) begin
            return 33'(mag - {2'b00, db});
        end
        return '0;
    endfunction

    // Cap the rescaled magnitude and restore the sign
    function automatic logic signed [15:0] db_finish(input logic signed [37:0] r,
                                                     input logic neg);
        logic [15:0] m;
        if (r > 38'sd32768) begin
            m = 16'h8000;
        end else begin
            m = r[15:0];
        end
        if (neg) begin
            return 16'(~m + 16'd1);
        end
        if (m[15]) begin
            return 16'sh7FFF;
        end
        return m;
    endfunction

    // Deadbanded twist times 1.5 with floor
    function automatic logic signed [16:0] d3_z(input logic signed [37:0] r);
        logic signed [15:0] dd;
        logic signed [17:0] t3;
        dd = db_finish(r, r_t[15]);
        t3 = 18'(dd) + 18'(dd) + 18'(dd);
        return t3[17:1];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
        if (v > 38'sd32767) begin
            return 16'sh7FFF;
        end
        if (v < -38'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_in_stall = r_run;
    assign in_acc     = i_in_valid && !r_run;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ctrl       = ucode(r_step);

    assign o_out_valid         = r_out_valid;
    assign o_front_left_drive  = r_fl;
    assign o_front_right_drive = r_fr;
    assign o_rear_left_drive   = r_rl;
    assign o_rear_right_drive  = r_rr;

    // register readback
    always_comb begin
        case (t_reg'(paddr[4:2]))
            REG_DEADBAND: prdata = 32'(r_deadband);
            REG_RESCALE:  prdata = 32'(r_rescale);
            REG_GYRO_EN:  prdata = 32'(r_gyro_en);
            REG_OL_GAIN:  prdata = 32'(r_ol_gain);
            REG_KP:       prdata = 32'(r_kp);
            REG_KI:       prdata = 32'(r_ki);
            default:      prdata = '0;
        endcase
    end

    // configuration writes; the host must write only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= 15'd3277;
            r_rescale  <= 16'd4551;
            r_gyro_en  <= 1'b1;
            r_ol_gain  <= 16'd1024;
            r_kp       <= 16'd4096;
            r_ki       <= 16'd82;
        end else if (cfg_wr) begin
            case (t_reg'(paddr[4:2]))
                REG_DEADBAND: r_deadband <= pwdata[14:0];
                REG_RESCALE:  r_rescale  <= pwdata[15:0];
                REG_GYRO_EN:  r_gyro_en  <= pwdata[0];
                REG_OL_GAIN:  r_ol_gain  <= pwdata[15:0];
                REG_KP:       r_kp       <= pwdata[15:0];
                REG_KI:       r_ki       <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // Select multiplier operands; gains enter as positive 17-bit values
    always_comb begin
        case (ctrl.msrc)
            MS_X: begin
                mul_a = db_excess(r_x, r_deadband);
                mul_b = {1'b0, r_rescale};
            end
            MS_Y: begin
                mul_a = db_excess(r_y, r_deadband);
                mul_b = {1'b0, r_rescale};
            end
            MS_T: begin
                mul_a = db_excess(r_t, r_deadband);
                mul_b = {1'b0, r_rescale};
            end
            MS_KP: begin
                mul_a = 33'(r_err);
                mul_b = {1'b0, r_kp};
            end
            MS_KI: begin
                mul_a = 33'(r_sum);
                mul_b = {1'b0, r_ki};
            end
            MS_OL: begin
                mul_a = 33'(r_z);
                mul_b = {1'b0, r_ol_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round the registered product to Q.12 with floor
    assign prod_bias = r_prod + 50'sd2048;
    assign prod_rnd  = prod_bias[49:12];

    assign jump = (ctrl.jmp == J_ALWAYS) || ((ctrl.jmp == J_OPEN) && !r_gyro_en);

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_run) begin
                if (in_acc) begin
                    r_run  <= 1'b1;
                    r_step <= '0;
                end
            end else if (ctrl.wb == WB_OUT) begin
                // hold the last step until the result register frees up
                if (out_free) begin
                    r_run  <= 1'b0;
                    r_step <= '0;
                end
            end else if (jump) begin
                r_step <= ctrl.target;
            end else begin
                r_step <= r_step + 4'd1;
            end

            if (r_run && (ctrl.wb == WB_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // integrator: the only datapath state that reset clears
    always_ff @(posedge i_clk) begin
        logic signed [32:0] s;
        s = {r_sum[31], r_sum} + 33'(r_err);
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_run && (ctrl.wb == WB_ERR)) begin
            if (s[32] != s[31]) begin
                r_sum <= s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
            end else begin
                r_sum <= s[31:0];
            end
        end
    end

    // datapath payload registers
    always_ff @(posedge i_clk) begin
        logic signed [15:0] d;
        logic signed [17:0] d3;
        logic signed [16:0] f;
        logic signed [37:0] fe, se;

        d  = db_finish(prod_rnd, r_t[15]);
        d3 = 18'(d) + 18'(d) + 18'(d);
        f  = 17'sd0 - 17'(r_dy);
        fe = 38'(f);
        se = 38'(r_strafe);

        if (in_acc) begin
            r_x    <= i_stick_x;
            r_y    <= i_stick_y;
            r_t    <= i_stick_twist;
            r_ten  <= i_twist_enable;
            r_meas <= i_measured_yaw_rate;
        end

        r_prod <= mul_a * mul_b;

        if (r_run) begin
            case (ctrl.wb)
                WB_X:    r_strafe <= db_finish(prod_rnd, r_x[15]);
                WB_Y:    r_dy     <= db_finish(prod_rnd, r_y[15]);
                // twist times 1.5 with floor, zero without the enable
                WB_T:    r_z      <= r_ten ? d3[17:1] : '0;
                WB_ERR:  ;
                WB_TSET: r_turn   <= prod_rnd;
                WB_TADD: r_turn   <= r_turn + prod_rnd;
                WB_OUT: begin
                    if (out_free) begin
                        r_fl <= sat16(fe + se + r_turn);
                        r_fr <= sat16(se - fe + r_turn);
                        r_rl <= sat16(fe - se + r_turn);
                        r_rr <= sat16(r_turn - fe - se);
                    end
                end
                default: ;
            endcase
        end
    end

    // yaw-rate error, taken at the twist writeback step, the step before the integrator update
    always_ff @(posedge i_clk) begin
        if (r_run && (ctrl.wb == WB_T)) begin
            r_err <= 18'(r_ten ? d3_z(prod_rnd) : 17'sd0) - 18'(r_meas);
        end
    end

endmodule
